[rtl/gpo_pkg.sv]
// types, constants and codes shared by the gateway priority order block
`default_nettype none

package gpo_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SLOT_W      = 6;
    localparam int GW_W        = 32;
    localparam int PRIO_W      = 32;
    localparam int MAX_OUT_W   = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_PREFERRED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUT   = 2'd2;

    localparam logic [SLOT_W-1:0]    PREFERRED_RST = 6'd63;
    localparam logic [SLOT_W-1:0]    SKIP_RST      = 6'd63;
    localparam logic [MAX_OUT_W-1:0] MAX_OUT_RST   = 7'd8;

    typedef enum logic
    {
        ST_LOAD,
        ST_EMIT
    } state_t;

    typedef struct packed
    {
        logic                     vld;
        logic signed [PRIO_W-1:0] prio;
        logic                     pref;
        logic [GW_W-1:0]          gw;
        logic [SLOT_W-1:0]        slot;
    } entry_t;

    typedef struct packed
    {
        logic ins;
        logic shift;
        logic clr;
    } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/gpo_cell.sv]
// one cell of the ordering chain: insertion compare and shift-out stage
`default_nettype none

module gpo_cell
    import gpo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  entry_t    new_entry,
    input  entry_t    prev_entry,
    input  logic      prev_beats,
    input  entry_t    next_entry,
    output entry_t    cur_entry,
    output logic      beats
);

    entry_t entry_reg;
    entry_t entry_next;

    // new entry goes ahead of this one
    always_comb
    begin
        beats = !entry_reg.vld
             || (new_entry.prio > entry_reg.prio)
             || ((new_entry.prio == entry_reg.prio) && new_entry.pref && !entry_reg.pref);
    end

    always_comb
    begin
        entry_next = entry_reg;
        priority if (cmd.clr)
        begin
            entry_next.vld = 1'b0;
        end
        else if (cmd.shift)
        begin
            entry_next = next_entry;
        end
        else if (cmd.ins)
        begin
            priority if (prev_beats)
            begin
                entry_next = prev_entry;
            end
            else if (beats)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign cur_entry = entry_reg;

endmodule

`default_nettype wire

[rtl/gateway_priority_order_top.sv]
// top level of the gateway priority order block: load control, cell chain, result port
`default_nettype none

// Slots are loaded one request per cycle in slot order; each usable slot is inserted
// into a chain of MAX_ENTRIES cells kept sorted by descending priority, the preferred
// slot ahead of its level and the rest in slot order. After the request that carries
// tlast, s_tready drops and results leave the head of the chain one per cycle while
// m_tready is high, up to max_out of them, or a single result with found low if no slot
// qualifies or max_out is zero. s_tready returns in the cycle after the final result
// is taken. Configuration must be written only while idle; the block does not enforce it.
module gateway_priority_order_top
    import gpo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // gateway_addr, slot_priority
    input  logic                  s_tuser,   // present
    input  logic                  s_tlast,   // last_entry
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // cand_gateway, cand_slot, zero fill
    output logic                  m_tuser,   // found
    output logic                  m_tlast    // last_result
);

    logic [SLOT_W-1:0]    preferred_reg;
    logic [SLOT_W-1:0]    skip_reg;
    logic [MAX_OUT_W-1:0] max_out_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [MAX_OUT_W-1:0] emitted_reg;
    logic [MAX_OUT_W-1:0] emitted_next;
    state_t               state_reg;
    state_t               state_next;

    logic                 s_acc;
    logic                 m_acc;
    logic                 room;
    logic                 usable;
    logic                 null_res;
    logic                 last_res;
    logic [SLOT_W-1:0]    cur_slot;
    logic [GW_W-1:0]      in_gw;
    entry_t               new_entry;
    cell_cmd_t            cmd;
    entry_t               lane [0:MAX_ENTRIES+1];
    logic [MAX_ENTRIES:0] beat;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign room     = (count_reg < CNT_W'(MAX_ENTRIES));
    assign cur_slot = SLOT_W'(count_reg);
    assign in_gw    = s_tdata[GW_W-1:0];
    assign usable   = s_tuser && (in_gw != '0) && (cur_slot != skip_reg);

    always_comb
    begin
        new_entry.vld  = 1'b1;
        new_entry.prio = s_tdata[GW_W+PRIO_W-1:GW_W];
        new_entry.pref = (cur_slot == preferred_reg);
        new_entry.gw   = in_gw;
        new_entry.slot = cur_slot;
    end

    // cell chain
    assign lane[0]               = '0;
    assign lane[MAX_ENTRIES + 1] = '0;
    assign beat[0]               = 1'b0;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        gpo_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .new_entry  (new_entry),
            .prev_entry (lane[i]),
            .prev_beats (beat[i]),
            .next_entry (lane[i+2]),
            .cur_entry  (lane[i+1]),
            .beats      (beat[i+1])
        );
    end

    assign null_res = !lane[1].vld || (max_out_reg == '0);
    assign last_res = null_res || !lane[2].vld
                   || ({1'b0, emitted_reg} + 8'd1 == {1'b0, max_out_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_acc && s_tlast)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (m_acc && last_res)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs and chain control
    always_comb
    begin
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        cmd          = '0;
        count_next   = count_reg;
        emitted_next = emitted_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_acc)
                begin
                    cmd.ins    = room && usable;
                    count_next = s_tlast ? '0 : (room ? count_reg + 1'b1 : count_reg);
                end
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_acc)
                begin
                    cmd.clr      = last_res;
                    cmd.shift    = !last_res;
                    emitted_next = last_res ? '0 : emitted_reg + 1'b1;
                end
            end
            default:
            begin
                cmd.clr = 1'b1;
            end
        endcase
    end

    assign m_tdata = {{(M_DATA_W - GW_W - SLOT_W){1'b0}},
                      (null_res ? {SLOT_W{1'b0}} : lane[1].slot),
                      (null_res ? {GW_W{1'b0}} : lane[1].gw)};
    assign m_tuser = !null_res;
    assign m_tlast = last_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            emitted_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            emitted_reg <= emitted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preferred_reg <= PREFERRED_RST;
            skip_reg      <= SKIP_RST;
            max_out_reg   <= MAX_OUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_PREFERRED: preferred_reg <= cfg_wdata[SLOT_W-1:0];
                CFG_SKIP:      skip_reg      <= cfg_wdata[SLOT_W-1:0];
                CFG_MAX_OUT:   max_out_reg   <= cfg_wdata[MAX_OUT_W-1:0];
                default:       ;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("load and result phases overlap");

    a_null_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("no-candidate result not marked last");

    a_last_in_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("final slot did not start result phase");

    a_last_out_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && (count_reg == '0)))
        else $error("job did not return to load phase");

endmodule

`default_nettype wire

[tb/gateway_order_checker.sv]
`timescale 1ns / 1ps
// checker for gateway_priority_order_top: predicts candidate order and compares results
module gateway_order_checker
    import gpo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // gateway_addr, slot_priority
    input  logic                  s_tuser,   // present
    input  logic                  s_tlast,   // last_entry
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,   // cand_gateway, cand_slot, zero fill
    input  logic                  m_tuser,   // found
    input  logic                  m_tlast,   // last_result
    output int                    errors,
    output int                    pending
);

    typedef struct packed
    {
        logic [GW_W-1:0]   gw;
        logic [SLOT_W-1:0] slot;
        logic              found;
        logic              last;
    } cand_t;

    cand_t                    cand_expected[$];
    cand_t                    want;
    logic [GW_W-1:0]          gw_tab[MAX_ENTRIES];
    logic signed [PRIO_W-1:0] prio_tab[MAX_ENTRIES];
    logic                     usable_tab[MAX_ENTRIES];
    int                       load_cnt;
    logic [SLOT_W-1:0]        pref_slot;
    logic [SLOT_W-1:0]        skip_slot;
    logic [MAX_OUT_W-1:0]     max_out;
    logic [GW_W-1:0]          got_gw;
    logic [SLOT_W-1:0]        got_slot;

    // walk the priority levels downward, preferred slot first within a level
    function automatic void rank_candidates(input int n);
        int                       written;
        int                       pref;
        int                       skip;
        logic signed [PRIO_W-1:0] level;
        logic signed [PRIO_W-1:0] lvl_next;
        bit                       level_seen;
        bit                       next_seen;
        bit                       done;
        written    = 0;
        pref       = pref_slot;
        skip       = skip_slot;
        level      = '0;
        level_seen = 1'b0;
        done       = 1'b0;
        while (!done)
        begin
            next_seen = 1'b0;
            lvl_next  = '0;
            for (int i = 0; i < n; i++)
            begin
                if (usable_tab[i] && i != skip && !(level_seen && prio_tab[i] >= level))
                begin
                    if (!next_seen || prio_tab[i] > lvl_next)
                    begin
                        lvl_next  = prio_tab[i];
                        next_seen = 1'b1;
                    end
                end
            end
            if (!next_seen)
                done = 1'b1;
            else
            begin
                level      = lvl_next;
                level_seen = 1'b1;
                if (pref < n && pref != skip && usable_tab[pref] && prio_tab[pref] == level
                    && written < max_out)
                begin
                    cand_expected.push_back({gw_tab[pref], pref_slot, 1'b1, 1'b0});
                    written++;
                end
                for (int i = 0; i < n && written < max_out; i++)
                begin
                    if (i != pref && i != skip && usable_tab[i] && prio_tab[i] == level)
                    begin
                        cand_expected.push_back({gw_tab[i], SLOT_W'(i), 1'b1, 1'b0});
                        written++;
                    end
                end
            end
        end
        if (written == 0)
            cand_expected.push_back({{GW_W{1'b0}}, {SLOT_W{1'b0}}, 1'b0, 1'b0});
        cand_expected[cand_expected.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pref_slot = PREFERRED_RST;
            skip_slot = SKIP_RST;
            max_out   = MAX_OUT_RST;
            load_cnt  = 0;
            for (int i = 0; i < MAX_ENTRIES; i++)
                usable_tab[i] = 1'b0;
            cand_expected.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_PREFERRED: pref_slot = cfg_wdata[SLOT_W-1:0];
                    CFG_SKIP:      skip_slot = cfg_wdata[SLOT_W-1:0];
                    CFG_MAX_OUT:   max_out   = cfg_wdata[MAX_OUT_W-1:0];
                    default:       ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                // requests past the table size are dropped but tlast still counts
                if (load_cnt < MAX_ENTRIES)
                begin
                    gw_tab[load_cnt]     = s_tdata[GW_W-1:0];
                    prio_tab[load_cnt]   = s_tdata[GW_W+PRIO_W-1:GW_W];
                    usable_tab[load_cnt] = s_tuser && (s_tdata[GW_W-1:0] != '0);
                    load_cnt++;
                end
                if (s_tlast)
                begin
                    rank_candidates(load_cnt);
                    load_cnt = 0;
                end
            end
            if (m_tvalid && m_tready)
            begin
                got_gw   = m_tdata[GW_W-1:0];
                got_slot = m_tdata[GW_W+SLOT_W-1:GW_W];
                if (cand_expected.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result gw %h slot %0d found %0b last %0b",
                             $time, got_gw, got_slot, m_tuser, m_tlast);
                end
                else
                begin
                    want = cand_expected.pop_front();
                    if (got_gw !== want.gw || got_slot !== want.slot
                        || m_tuser !== want.found || m_tlast !== want.last)
                    begin
                        errors++;
                        $display("%0t: expected %h/%0d/%0b/%0b got %h/%0d/%0b/%0b",
                                 $time, want.gw, want.slot, want.found, want.last,
                                 got_gw, got_slot, m_tuser, m_tlast);
                    end
                end
            end
            pending = cand_expected.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// testbench top for gateway_priority_order_top: slot tables, register phases, idling and verdict
module tb
    import gpo_pkg::*;
();

    localparam int STALL_LIMIT = 2000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;   // gateway_addr, slot_priority
    logic                  s_tuser   = 1'b0; // present
    logic                  s_tlast   = 1'b0; // last_entry
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;          // cand_gateway, cand_slot, zero fill
    logic                  m_tuser;          // found
    logic                  m_tlast;          // last_result
    int                    errors;
    int                    pending;
    bit                    calm      = 1'b0;
    int                    stall_cnt = 0;
    int                    sent;
    int                    job_len;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gateway_priority_order_top dut (.*);

    gateway_order_checker chk (.*);

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(99) >= 9);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("[gateway_priority_order_top] ERROR");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    task automatic send_slot(input logic [GW_W-1:0] gw, input logic signed [PRIO_W-1:0] prio,
                             input logic present, input logic last);
        if (!calm && $urandom_range(99) < 9)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {prio, gw};
        s_tuser  <= present;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    // hold off until every candidate is back and the block has returned to loading
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [SLOT_W-1:0] pref, input logic [SLOT_W-1:0] skip,
                             input logic [MAX_OUT_W-1:0] maxo);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_PREFERRED;
        cfg_wdata <= CFG_DATA_W'(pref);
        @(posedge clk);
        cfg_addr  <= CFG_SKIP;
        cfg_wdata <= CFG_DATA_W'(skip);
        @(posedge clk);
        cfg_addr  <= CFG_MAX_OUT;
        cfg_wdata <= CFG_DATA_W'(maxo);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [SLOT_W-1:0] pick_slot();
        case ($urandom_range(5))
            0:       return '0;
            1:       return SLOT_W'(MAX_ENTRIES - 1);
            2:       return SLOT_W'(MAX_ENTRIES);
            3:       return '1;
            default: return SLOT_W'($urandom_range(MAX_ENTRIES - 1));
        endcase
    endfunction

    task automatic run_job(input int n);
        logic [GW_W-1:0]          gw;
        logic signed [PRIO_W-1:0] prio;
        for (int i = 0; i < n; i++)
        begin
            gw = ($urandom_range(9) == 0) ? '0 : $urandom;
            // mostly a few close levels so that ties and the preferred slot matter
            case ($urandom_range(9))
                0:       prio = 32'sh8000_0000;
                1:       prio = 32'sh7fff_ffff;
                2, 3:    prio = $urandom;
                default: prio = $signed(PRIO_W'($urandom_range(3))) - 1;
            endcase
            send_slot(gw, prio, $urandom_range(99) < 85, i == n - 1);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one usable slot, one absent slot, one slot with no gateway
        send_slot(32'hffff_ffff, 32'sh7fff_ffff, 1'b1, 1'b1);
        send_slot(32'h1234_5678, 32'sh0, 1'b0, 1'b1);
        send_slot(32'h0, 32'sh5, 1'b1, 1'b1);

        // full table plus two dropped requests, tlast on a dropped one
        for (int i = 0; i < 10; i++)
            send_slot((i == 3) ? 32'h0 : 32'h0a00_0001 + i,
                      (i % 3 == 0) ? 32'sh8000_0000 : (i % 3 == 1) ? 32'sh7fff_ffff : 32'sh0,
                      i != 5, i == 9);

        // preferred slot inside a tie, skipped slot, output cut short
        settle();
        write_cfg(6'd2, 6'd5, 7'd3);
        for (int i = 0; i < 6; i++)
            send_slot(32'hc0a8_0000 + i, (i == 4) ? 32'sh2 : 32'sh1, 1'b1, i == 5);

        // no output allowed
        settle();
        write_cfg(6'd0, 6'd0, 7'd0);
        send_slot(32'h0101_0101, 32'sh3, 1'b1, 1'b0);
        send_slot(32'h0202_0202, 32'sh3, 1'b1, 1'b1);

        for (int phase = 0; phase < 8; phase++)
        begin
            settle();
            calm = (phase == 3);
            case (phase)
                0:       write_cfg(6'd63, 6'd63, 7'd64);
                1:       write_cfg(6'd0, 6'(MAX_ENTRIES - 1), 7'd1);
                2:       write_cfg(6'(MAX_ENTRIES - 1), 6'd0, 7'd0);
                default: write_cfg(pick_slot(), pick_slot(), 7'($urandom_range(64)));
            endcase
            sent = 0;
            while (sent < 45)
            begin
                job_len = ($urandom_range(9) == 0) ? $urandom_range(12, 9)
                                                   : $urandom_range(MAX_ENTRIES, 1);
                run_job(job_len);
                sent += job_len;
            end
        end

        settle();
        repeat (16) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[gateway_priority_order_top] OK");
        else
            $display("[gateway_priority_order_top] ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/gpo_pkg.sv
rtl/gpo_cell.sv
rtl/gateway_priority_order_top.sv
tb/gateway_order_checker.sv
tb/tb.sv
